// File: hw/rtl/crc16tc_pkg.sv
// Shared types, constants and the byte-wide CRC update for the CRC-16 trailer checker.
// No dependencies.
package crc16tc_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h8408;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CRC_W    = 16;

    // Held-byte fill levels of the two-byte delay
    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE  = 2'd1;
    localparam logic [1:0] HELD_FULL = 2'd2;

    // One received frame byte
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } in_item_t;

    // One frame check result
    typedef struct packed {
        logic             crc_ok;
        logic [CRC_W-1:0] computed_crc;
        logic [CRC_W-1:0] received_crc;
        logic             short_frame;
    } out_item_t;

    // Reflected CRC-16 update by one byte, LSB first
    function automatic logic [CRC_W-1:0] crc_byte(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] b
    );
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/crc16_trailer_check_top.sv
// CRC-16 (reflected 0x8408, init 0xFFFF) frame trailer checker, top level.
// Byte channel in, one check result per frame out; the byte stream is accepted
// one item per cycle while byte_ready is high.
// The result item is valid in the cycle after the final byte is accepted.
// Throughput: one byte per cycle while byte_ready is high, set by the
// combinational byte-wide CRC update feeding the running CRC register.
// byte_ready is high whenever the result register is empty or being emptied;
// while a result waits with result_ready low, byte_ready is low for every
// byte, final or not, until result_ready is seen.
// Frames under two bytes report short_frame with crc_ok low.
// Reset (rst_n low) clears the running CRC, the delay fill count and the
// result valid flag; the first byte after reset starts a new frame.
// Bytes that do not end a frame produce no result.
module crc16_trailer_check_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_ready,
    input  crc16tc_pkg::in_item_t  byte_item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output crc16tc_pkg::out_item_t result_item
);
    import crc16tc_pkg::*;

    logic      fire;
    logic      can_accept;
    out_item_t frame_result;

    assign byte_ready = can_accept;
    assign fire       = byte_valid && can_accept;

    crc16tc_frame u_frame (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (byte_item),
        .result (frame_result)
    );

    crc16tc_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (fire && byte_item.last_byte),
        .load_item    (frame_result),
        .can_accept   (can_accept),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

endmodule

// File: hw/rtl/crc16tc_frame.sv
// Frame state: running CRC, two-byte trailer delay and result formation.
// Depends on crc16tc_pkg.
module crc16tc_frame (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  crc16tc_pkg::in_item_t  item,
    output crc16tc_pkg::out_item_t result
);
    import crc16tc_pkg::*;

    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [1:0]        count_reg, count_next;
    logic [BYTE_W-1:0] held_reg [2];

    logic [CRC_W-1:0] crc_eff;
    logic [CRC_W-1:0] rx_crc;
    logic             is_short;

    // Oldest held byte enters the CRC once the delay is full
    always_comb
    begin
        crc_eff  = (count_reg == HELD_FULL) ? crc_byte(crc_reg, held_reg[0]) : crc_reg;
        is_short = (count_reg == HELD_NONE);
        rx_crc   = {item.data_byte, held_reg[1]};
    end

    // Result for the final byte of a frame
    always_comb
    begin
        result.short_frame  = is_short;
        result.computed_crc = is_short ? CRC_INIT : crc_eff;
        result.received_crc = is_short ? '0 : rx_crc;
        result.crc_ok       = !is_short && (crc_eff == rx_crc);
    end

    // Next state: back to reset values after the final byte
    always_comb
    begin
        crc_next   = crc_reg;
        count_next = count_reg;
        if (fire)
        begin
            if (item.last_byte)
            begin
                crc_next   = CRC_INIT;
                count_next = HELD_NONE;
            end
            else
            begin
                crc_next   = crc_eff;
                count_next = (count_reg == HELD_FULL) ? HELD_FULL : count_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_INIT;
            count_reg <= HELD_NONE;
        end
        else
        begin
            crc_reg   <= crc_next;
            count_reg <= count_next;
        end
    end

    // Delay line; contents only read while the fill count marks them valid
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            held_reg[0] <= held_reg[1];
            held_reg[1] <= item.data_byte;
        end
    end

endmodule

// File: hw/rtl/crc16tc_out_reg.sv
// Result register with valid/ready towards the receiver; derives input ready.
// Depends on crc16tc_pkg.
module crc16tc_out_reg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  crc16tc_pkg::out_item_t load_item,
    output logic                   can_accept,
    output logic                   result_valid,
    input  logic                   result_ready,
    output crc16tc_pkg::out_item_t result_item
);
    import crc16tc_pkg::*;

    logic      valid_reg, valid_next;
    out_item_t item_reg;

    // Space exists when empty or when the held item leaves this cycle
    assign can_accept = !valid_reg || result_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (result_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= load_item;
    end

    assign result_valid = valid_reg;
    assign result_item  = item_reg;

endmodule

// File: hw/rtl/crc16tc_checker.sv
// Port-level checks for the CRC-16 trailer checker, bound to the top level.
// Depends on crc16tc_pkg and crc16_trailer_check_top.
module crc16tc_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   byte_ready,
    input logic                   result_valid,
    input logic                   result_ready,
    input crc16tc_pkg::out_item_t result_item
);
    import crc16tc_pkg::*;

    // A short frame carries fixed fields and never passes
    a_short_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.short_frame |->
            !result_item.crc_ok && result_item.computed_crc == CRC_INIT &&
            result_item.received_crc == '0)
        else $error("short frame result fields wrong");

    // A pass implies the two CRCs agree
    a_ok_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.crc_ok |->
            result_item.computed_crc == result_item.received_crc)
        else $error("crc_ok set with differing CRCs");

    // Input stalls only behind a stalled result
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_ready |-> result_valid && !result_ready)
        else $error("byte_ready low without a stalled result");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_item))
        else $error("result item changed while stalled");

endmodule

bind crc16_trailer_check_top crc16tc_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_ready   (byte_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
);

// File: bench/crc16_frame_checker.sv
// Watches both channels of the CRC-16 trailer checker, predicts each frame result
// from the accepted bytes and compares it with what the block returns.
// Depends on crc16tc_pkg for the item types and CRC constants.
`timescale 1ns / 1ps

module crc16_frame_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    input  logic                   byte_ready,
    input  crc16tc_pkg::in_item_t  byte_item,
    input  logic                   result_valid,
    input  logic                   result_ready,
    input  crc16tc_pkg::out_item_t result_item,
    output int                     fail_count,
    output int                     pending,
    output int                     results_seen
);
    import crc16tc_pkg::*;

    // Predictor state: running CRC and the two-byte trailer delay
    logic [CRC_W-1:0]  run_crc;
    logic [BYTE_W-1:0] delay_line [2];
    logic [1:0]        delay_fill;
    out_item_t         verdict_q [$];

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        results_seen = 0;
    end

    // Reflected CRC-16, one data bit at a time, LSB first
    function automatic logic [CRC_W-1:0] fold_octet(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] octet
    );
        logic fb;
        for (int i = 0; i < BYTE_W; i++)
        begin
            fb  = crc[0] ^ octet[i];
            crc = {1'b0, crc[CRC_W-1:1]};
            if (fb)
                crc = crc ^ CRC_POLY;
        end
        return crc;
    endfunction

    task automatic clear_frame();
        run_crc       = CRC_INIT;
        delay_line[0] = '0;
        delay_line[1] = '0;
        delay_fill    = HELD_NONE;
    endtask

    task automatic report_mismatch(input string what, input logic [CRC_W-1:0] want,
                                   input logic [CRC_W-1:0] got);
        $display("[%0t] frame check: result %0d %s: expected 0x%04h, got 0x%04h",
                 $time, results_seen, what, want, got);
        fail_count++;
    endtask

    // One accepted byte through the delay line; a final byte yields a verdict
    task automatic predict_byte(input in_item_t it);
        out_item_t v;
        logic      lone;
        lone = (delay_fill == HELD_NONE);
        if (delay_fill == HELD_FULL)
            run_crc = fold_octet(run_crc, delay_line[0]);
        delay_line[0] = delay_line[1];
        delay_line[1] = it.data_byte;
        if (delay_fill != HELD_FULL)
            delay_fill = delay_fill + 2'd1;
        if (it.last_byte)
        begin
            if (lone)
            begin
                v.crc_ok       = 1'b0;
                v.computed_crc = CRC_INIT;
                v.received_crc = '0;
                v.short_frame  = 1'b1;
            end
            else
            begin
                v.received_crc = {delay_line[1], delay_line[0]};
                v.computed_crc = run_crc;
                v.crc_ok       = (run_crc == v.received_crc);
                v.short_frame  = 1'b0;
            end
            verdict_q.push_back(v);
            clear_frame();
        end
    endtask

    task automatic compare_result(input out_item_t got);
        out_item_t want;
        results_seen++;
        if (verdict_q.size() == 0)
        begin
            report_mismatch("arrived with no frame pending, computed_crc", '0,
                            got.computed_crc);
        end
        else
        begin
            want = verdict_q.pop_front();
            if (got.crc_ok !== want.crc_ok)
                report_mismatch("crc_ok", 16'(want.crc_ok), 16'(got.crc_ok));
            if (got.computed_crc !== want.computed_crc)
                report_mismatch("computed_crc", want.computed_crc, got.computed_crc);
            if (got.received_crc !== want.received_crc)
                report_mismatch("received_crc", want.received_crc, got.received_crc);
            if (got.short_frame !== want.short_frame)
                report_mismatch("short_frame", 16'(want.short_frame),
                                16'(got.short_frame));
        end
    endtask

    // Results are taken before bytes: a byte accepted now cannot have its
    // result on the output at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_frame();
            verdict_q.delete();
        end
        else
        begin
            if (result_valid && result_ready)
                compare_result(result_item);
            if (byte_valid && byte_ready)
                predict_byte(byte_item);
        end
        pending = verdict_q.size();
    end

endmodule

// File: bench/tb_crc16_trailer_check_top.sv
// Stimulus and verdict for the CRC-16 trailer checker: directed and random frames,
// random idling on both sides, one long result hold-off.
// Depends on crc16tc_pkg, crc16_trailer_check_top and crc16_frame_checker.
`timescale 1ns / 1ps

module tb_crc16_trailer_check_top;
    import crc16tc_pkg::*;

    typedef logic [BYTE_W-1:0] octet_q_t [$];

    localparam int BYTE_TARGET = 750;
    localparam int HOLD_CYCLES = 240;
    localparam int DRAIN_LIMIT = 2000;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      byte_valid   = 1'b0;
    logic      byte_ready;
    in_item_t  byte_item    = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    out_item_t result_item;

    int fail_count;
    int pending;
    int results_seen;

    // Pacing controls for the sender and the receiver
    bit calm      = 1'b0;
    bit burst     = 1'b0;
    bit hold_due  = 1'b0;
    int bytes_sent;
    int frames_sent;
    int lone_frames;
    int bad_frames;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    crc16_trailer_check_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    crc16_frame_checker frame_watch (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    // Append the little-endian CRC trailer to a payload
    function automatic octet_q_t seal(input octet_q_t body);
        octet_q_t         fr;
        logic [CRC_W-1:0] c;
        c  = CRC_INIT;
        fr = body;
        foreach (body[k])
        begin
            c = c ^ {8'h00, body[k]};
            for (int j = 0; j < BYTE_W; j++)
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        fr.push_back(c[7:0]);
        fr.push_back(c[15:8]);
        return fr;
    endfunction

    // Offer one byte item after a random gap and wait for it to be taken
    task automatic send_byte(input logic [BYTE_W-1:0] d, input logic fin);
        int gap;
        gap = (calm || burst) ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= '{data_byte: d, last_byte: fin};
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input octet_q_t fr);
        for (int i = 0; i < fr.size(); i++)
            send_byte(fr[i], i == fr.size() - 1);
        frames_sent++;
        if (fr.size() == 1)
            lone_frames++;
    endtask

    // Random frame: a few one-byte frames, mostly short payloads, some long,
    // and roughly a quarter with one flipped bit somewhere
    task automatic random_frame(input int max_len);
        octet_q_t body;
        octet_q_t fr;
        int       r;
        int       len;
        int       idx;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            fr.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(11, max_len)
                                              : $urandom_range(0, 10);
            if (len > max_len)
                len = max_len;
            repeat (len) body.push_back(8'($urandom_range(0, 255)));
            fr = seal(body);
            if (r < 32)
            begin
                idx = $urandom_range(0, fr.size() - 1);
                fr[idx] = fr[idx] ^ (8'h01 << $urandom_range(0, 7));
                bad_frames++;
            end
        end
        send_frame(fr);
    endtask

    // Result side: random stalls, one long hold-off when asked
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_due)
            begin
                hold_due = 1'b0;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = calm ? 0 : $urandom_range(0, 19);
                if (stall > 0)
                begin
                    result_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
        end
    end

    // Stimulus and verdict
    initial
    begin
        octet_q_t fr;
        octet_q_t none;
        bit       hold_done;
        int       spin;
        int       leftover;
        hold_done = 1'b0;
        leftover  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one-byte frames, empty payload, extremes of the byte range
        send_frame('{8'hFF});
        send_frame('{8'h00});
        send_frame(seal(none));
        send_frame('{8'h00, 8'h00});
        send_frame(seal('{8'h80}));
        fr = seal('{8'h01, 8'h7F});
        fr[3] = fr[3] ^ 8'h80;          // bad high trailer byte
        send_frame(fr);
        fr = seal('{8'hAA, 8'h0F});
        fr[2] = fr[2] ^ 8'h01;          // bad low trailer byte
        send_frame(fr);
        send_frame(seal('{8'hFF, 8'h00, 8'h55}));
        bad_frames += 3;

        // Random frames in phases, some with no idling at all
        while (bytes_sent < BYTE_TARGET)
        begin
            calm = ($urandom_range(0, 3) == 0);
            repeat (12)
            begin
                if (!hold_done && bytes_sent >= BYTE_TARGET / 3)
                begin
                    // Back-to-back small frames against a held result channel
                    hold_done = 1'b1;
                    hold_due  = 1'b1;
                    burst     = 1'b1;
                    repeat (8) random_frame(1);
                    burst     = 1'b0;
                end
                random_frame(40);
            end
        end
        byte_valid <= 1'b0;
        calm = 1'b0;

        // Drain outstanding results, then allow for the output register
        spin = 0;
        @(negedge clk);
        while (pending != 0 && spin < DRAIN_LIMIT)
        begin
            @(negedge clk);
            spin++;
        end
        if (pending != 0)
        begin
            leftover = pending;
            $display("%0d frame result(s) never returned", leftover);
        end
        repeat (4) @(posedge clk);

        $display("Sent %0d bytes in %0d frames (%0d one-byte, %0d corrupted); %0d results",
                 bytes_sent, frames_sent, lone_frames, bad_frames, results_seen);
        $display("checked, including a %0d-cycle result hold-off under full input load.",
                 HOLD_CYCLES);
        if (fail_count == 0 && leftover == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
